// ----- rtl/mpvs_pkg.sv -----
// Package: shared types, constants and the arctangent table for the view sector counter.
`default_nettype none
package mpvs_pkg;
	localparam int MAX_POINTS = 1024;
	localparam int ANGLE_BITS = 32;
	localparam int CORDIC_ITERS = 32;
	localparam int ADDR_W = $clog2(MAX_POINTS);
	localparam int CNT_W = 11;
	localparam int COORD_W = 30;
	localparam int CFG_W = 30;
	localparam int CFG_IDX_W = 2;
	localparam logic [CNT_W-1:0] COUNT_SAT = 11'd2047;
	localparam logic [CFG_IDX_W-1:0] REG_VIEW_DEGREES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VIEWER_X = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VIEWER_Y = 2'd2;

	typedef struct packed {
		logic [COORD_W-1:0] point_x;
		logic [COORD_W-1:0] point_y;
		logic               final_point;
	} in_word_t;

	typedef struct packed {
		logic [CNT_W-1:0] visible_count;
		logic             overflow;
	} out_word_t;

	typedef struct packed {
		logic        start;
		logic [31:0] dx;
		logic [31:0] dy;
	} cordic_req_t;

	function automatic logic [ANGLE_BITS-1:0] atan_entry(input logic [4:0] i);
		logic [31:0] e;
		begin
			case (i)
				5'd0: e = 32'd536870912;  5'd1: e = 32'd316933406;
				5'd2: e = 32'd167458907;  5'd3: e = 32'd85004756;
				5'd4: e = 32'd42667331;   5'd5: e = 32'd21354465;
				5'd6: e = 32'd10679838;   5'd7: e = 32'd5340245;
				5'd8: e = 32'd2670163;    5'd9: e = 32'd1335087;
				5'd10: e = 32'd667544;    5'd11: e = 32'd333772;
				5'd12: e = 32'd166886;    5'd13: e = 32'd83443;
				5'd14: e = 32'd41722;     5'd15: e = 32'd20861;
				5'd16: e = 32'd10430;     5'd17: e = 32'd5215;
				5'd18: e = 32'd2608;      5'd19: e = 32'd1304;
				5'd20: e = 32'd652;       5'd21: e = 32'd326;
				5'd22: e = 32'd163;       5'd23: e = 32'd81;
				5'd24: e = 32'd41;        5'd25: e = 32'd20;
				5'd26: e = 32'd10;        5'd27: e = 32'd5;
				5'd28: e = 32'd3;         5'd29: e = 32'd1;
				5'd30: e = 32'd1;         default: e = 32'd0;
			endcase
			return e;
		end
	endfunction
endpackage
`default_nettype wire

// ----- rtl/mpvs_ram.sv -----
// Generic single-port RAM with registered read.
`default_nettype none
module mpvs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

// ----- rtl/mpvs_cordic.sv -----
// Iterative CORDIC vectoring unit: one micro-rotation per cycle, gives a binary-angle bearing.
`default_nettype none
module mpvs_cordic (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire mpvs_pkg::cordic_req_t        req,
	output logic                              done,
	output logic [mpvs_pkg::ANGLE_BITS-1:0]   bearing
);
	// x grows by at most ~1.65 * sqrt(2) * 2^30: 34 bits signed suffices, keep margin
	localparam int XW = 36;
	logic signed [XW-1:0] x_q, y_q;
	logic [mpvs_pkg::ANGLE_BITS-1:0] z_q;
	logic [4:0] it_q;
	logic busy_q;
	logic signed [XW-1:0] dxe, dye, xs, ys;

	assign dxe = XW'(signed'(req.dx));
	assign dye = XW'(signed'(req.dy));
	assign xs = x_q >>> it_q;
	assign ys = y_q >>> it_q;
	assign bearing = z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			it_q <= '0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				it_q <= '0;
			end else if (busy_q) begin
				it_q <= it_q + 5'd1;
				if (it_q == 5'(mpvs_pkg::CORDIC_ITERS - 1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			if (dxe < 0) begin
				x_q <= -dxe;
				y_q <= -dye;
				z_q <= {1'b1, {(mpvs_pkg::ANGLE_BITS-1){1'b0}}};
			end else begin
				x_q <= dxe;
				y_q <= dye;
				z_q <= '0;
			end
		end else if (busy_q) begin
			if (y_q >= 0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + mpvs_pkg::atan_entry(it_q);
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - mpvs_pkg::atan_entry(it_q);
			end
		end
	end
endmodule
`default_nettype wire

// ----- rtl/max_points_in_view_sector.sv -----
// Top level of the view sector counter: loader, insertion sort, window sweep.
// Usage:
//  - Write view_degrees (index 0), viewer_x (1), viewer_y (2) through cfg_we /
//    cfg_index / cfg_data while idle. Indexes above 2 are ignored.
//  - Present one point word on in_word with start high; it is taken at the
//    edge where busy is low. A point equal to the viewer location only bumps
//    the origin count; a dropped point only sets the overflow bit. Either,
//    unless final, keeps busy high only through the wait state.
//  - Any other point runs the CORDIC unit (a start, 32 iterations, then the
//    returned bearing), then is insertion-sorted into the bearing RAM with a
//    read, a check and a write step per entry that moves up, and a store of
//    the bearing into its slot.
//  - The final_point word then passes the fov state, which latches the bound
//    floor(deg*2^32/360), taken by reciprocal multiplication, and the sweep
//    over the list extended by one turn: each right-pointer step passes the
//    read, latch, left-read and compare states, each left-pointer step the
//    left-read and compare states; an output state ends it.
//  - One result word appears on out_word with done high for one cycle, the
//    first cycle with busy low; the receiver cannot stall it. The set clears.
//  - Reset clears counts and control; the bearing RAM is not cleared, as
//    only entries below the stored count are ever read.
`default_nettype none
module max_points_in_view_sector (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire mpvs_pkg::in_word_t                  in_word,
	output logic                                     done,
	output mpvs_pkg::out_word_t                      out_word,
	input  wire logic                                cfg_we,
	input  wire logic [mpvs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [mpvs_pkg::CFG_W-1:0]          cfg_data
);
	localparam int AW = mpvs_pkg::ADDR_W;
	localparam int AB = mpvs_pkg::ANGLE_BITS;
	localparam int CW = mpvs_pkg::CNT_W;
	localparam int SW = AW + 2; // sweep index up to 2n

	// deg*2^32/360 = deg*2^29/45, and 2^29 = 45*11930464 + 32, so the bound is
	// deg*11930464 + floor(deg*32/45); the fraction uses ceil(2^20/45) = 23302.
	localparam logic [AB:0] FOV_WHOLE = 33'd11930464;
	localparam logic [23:0] FOV_FRAC_MUL = 24'd23302;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_CORDIC = 4'd1;
	localparam logic [3:0] ST_INS_RD = 4'd2;
	localparam logic [3:0] ST_INS_CK = 4'd3;
	localparam logic [3:0] ST_INS_WR = 4'd4;
	localparam logic [3:0] ST_FOV    = 4'd5;
	localparam logic [3:0] ST_RD_R   = 4'd6;
	localparam logic [3:0] ST_LAT_R  = 4'd7;
	localparam logic [3:0] ST_RD_L   = 4'd8;
	localparam logic [3:0] ST_CMP    = 4'd9;
	localparam logic [3:0] ST_OUT    = 4'd10;
	localparam logic [3:0] ST_WAIT   = 4'd11;

	logic [3:0] state_q;
	logic [8:0] view_degrees_q;
	logic [mpvs_pkg::COORD_W-1:0] viewer_x_q, viewer_y_q;
	logic [CW-1:0] stored_count_q, origin_count_q;
	logic dropped_q, final_q;
	logic [31:0] dx_q, dy_q;
	logic [AB-1:0] bearing_q;
	logic [AW:0] k_q;           // insertion slot, at most MAX_POINTS - 1
	logic [SW-1:0] r_q, l_q;
	logic [SW-1:0] best_q;      // window can span more than n entries
	logic [AB:0] er_q;          // extended bearing at r
	logic [AB:0] fov_q;
	logic c_busy_seen_q;
	logic ins_final_q;
	logic [AB-1:0] ram_rdata_hold_q;

	// RAM
	logic ram_we;
	logic [AW-1:0] ram_addr;
	logic [AB-1:0] ram_wdata, ram_rdata;

	mpvs_ram #(.WIDTH(AB), .DEPTH(mpvs_pkg::MAX_POINTS)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	mpvs_pkg::cordic_req_t creq;
	logic c_done;
	logic [AB-1:0] c_bearing;

	mpvs_cordic u_cordic (.clk(clk), .arst_n(arst_n), .req(creq), .done(c_done),
		.bearing(c_bearing));

	logic accept;
	logic is_origin;
	logic [31:0] dx_w, dy_w;
	logic [SW-1:0] n_ext, two_n;
	logic [SW-1:0] l_idx;
	logic [AB:0] el_w;
	logic [SW-1:0] win;
	logic [AB:0] fov_w;
	logic [CW:0] total_w;
	logic [CW-1:0] best_cap;

	assign accept = start && !busy;
	assign busy = (state_q != ST_IDLE);
	assign dx_w = 32'({2'b00, in_word.point_x}) - 32'({2'b00, viewer_x_q});
	assign dy_w = 32'({2'b00, in_word.point_y}) - 32'({2'b00, viewer_y_q});
	assign is_origin = (dx_w == 32'd0) && (dy_w == 32'd0);
	assign n_ext = SW'(stored_count_q);
	assign two_n = SW'({stored_count_q, 1'b0});
	always_comb begin
		creq.start = (state_q == ST_CORDIC) && (k_q == '0) && !c_busy_seen_q;
		creq.dx = dx_q;
		creq.dy = dy_q;
	end
	// left pointer's extended value; the RAM was read at l folded into [0, n)
	assign l_idx = (l_q >= n_ext) ? (l_q - n_ext) : l_q;
	assign el_w = (l_q >= n_ext) ? ({1'b0, ram_rdata} + {1'b1, {AB{1'b0}}})
		: {1'b0, ram_rdata};
	assign win = r_q - l_q + SW'(1);
	assign fov_w = (AB+1)'(view_degrees_q * FOV_WHOLE)
		+ (AB+1)'((view_degrees_q * FOV_FRAC_MUL) >> 15);
	assign best_cap = (best_q > n_ext) ? stored_count_q : CW'(best_q);
	assign total_w = {1'b0, best_cap} + {1'b0, origin_count_q};

	// RAM port steering
	always_comb begin
		ram_we = 1'b0;
		ram_addr = '0;
		ram_wdata = bearing_q;
		unique case (state_q) inside
			ST_INS_RD: ram_addr = AW'(k_q - (AW+1)'(1));
			ST_INS_WR: begin
				ram_we = 1'b1;
				ram_addr = AW'(k_q);
				ram_wdata = ram_rdata_hold_q;
			end
			ST_CORDIC: begin
				ram_we = ins_final_q;
				ram_addr = AW'(k_q);
				ram_wdata = bearing_q;
			end
			ST_RD_R: ram_addr = AW'((r_q >= n_ext) ? (r_q - n_ext) : r_q);
			ST_RD_L, ST_CMP: ram_addr = AW'(l_idx);
			default: ram_addr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			view_degrees_q <= 9'd90;
			viewer_x_q <= '0;
			viewer_y_q <= '0;
			stored_count_q <= '0;
			origin_count_q <= '0;
			dropped_q <= 1'b0;
			final_q <= 1'b0;
			done <= 1'b0;
			c_busy_seen_q <= 1'b0;
			ins_final_q <= 1'b0;
		end else begin
			done <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					mpvs_pkg::REG_VIEW_DEGREES: view_degrees_q <= cfg_data[8:0];
					mpvs_pkg::REG_VIEWER_X: viewer_x_q <= cfg_data;
					mpvs_pkg::REG_VIEWER_Y: viewer_y_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						final_q <= in_word.final_point;
						dx_q <= dx_w;
						dy_q <= dy_w;
						c_busy_seen_q <= 1'b0;
						ins_final_q <= 1'b0;
						k_q <= '0;
						if (is_origin) begin
							if (origin_count_q != mpvs_pkg::COUNT_SAT)
								origin_count_q <= origin_count_q + CW'(1);
							state_q <= in_word.final_point ? ST_FOV : ST_WAIT;
						end else if (stored_count_q == CW'(mpvs_pkg::MAX_POINTS)) begin
							dropped_q <= 1'b1;
							state_q <= in_word.final_point ? ST_FOV : ST_WAIT;
						end else begin
							state_q <= ST_CORDIC;
						end
					end
				end
				ST_WAIT: state_q <= ST_IDLE;
				ST_CORDIC: begin
					// first cycle starts the unit; done returns the bearing
					c_busy_seen_q <= 1'b1;
					if (ins_final_q) begin
						// slot write done this cycle
						stored_count_q <= stored_count_q + CW'(1);
						state_q <= final_q ? ST_FOV : ST_IDLE;
					end else if (c_done) begin
						bearing_q <= c_bearing;
						k_q <= (AW+1)'(stored_count_q);
						if (stored_count_q == '0) begin
							ins_final_q <= 1'b1;
						end else begin
							state_q <= ST_INS_RD;
						end
					end
				end
				ST_INS_RD: state_q <= ST_INS_CK;
				ST_INS_CK: begin
					if (ram_rdata > bearing_q) begin
						ram_rdata_hold_q <= ram_rdata;
						state_q <= ST_INS_WR;
					end else begin
						ins_final_q <= 1'b1;
						state_q <= ST_CORDIC;
					end
				end
				ST_INS_WR: begin
					k_q <= k_q - (AW+1)'(1);
					if (k_q == (AW+1)'(1)) begin
						ins_final_q <= 1'b1;
						state_q <= ST_CORDIC;
					end else begin
						state_q <= ST_INS_RD;
					end
				end
				ST_FOV: begin
					// latch the fov bound and open the sweep
					fov_q <= fov_w;
					r_q <= '0;
					l_q <= '0;
					best_q <= '0;
					state_q <= (stored_count_q == '0) ? ST_OUT : ST_RD_R;
				end
				ST_RD_R: state_q <= ST_LAT_R;
				ST_LAT_R: begin
					er_q <= (r_q >= n_ext) ? ({1'b0, ram_rdata} + {1'b1, {AB{1'b0}}})
						: {1'b0, ram_rdata};
					state_q <= ST_RD_L;
				end
				ST_RD_L: state_q <= ST_CMP;
				ST_CMP: begin
					if (er_q - el_w > fov_q) begin
						l_q <= l_q + SW'(1);
						state_q <= ST_RD_L;
					end else begin
						if (win > best_q) best_q <= win;
						if (r_q + SW'(1) == two_n) begin
							state_q <= ST_OUT;
						end else begin
							r_q <= r_q + SW'(1);
							state_q <= ST_RD_R;
						end
					end
				end
				ST_OUT: begin
					done <= 1'b1;
					out_word.visible_count <= total_w[CW] ? mpvs_pkg::COUNT_SAT
						: total_w[CW-1:0];
					out_word.overflow <= dropped_q;
					stored_count_q <= '0;
					origin_count_q <= '0;
					dropped_q <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_done_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == ST_OUT) else $error("result without output state");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stored_count_q <= CW'(mpvs_pkg::MAX_POINTS)) else $error("store count overrun");
	a_left_le_right: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CMP |-> l_q <= r_q) else $error("window pointers crossed");
`endif
endmodule
`default_nettype wire
